// ----- hdl/napt_pkg.sv -----
// Shared constants for the NAT address pool table: result status codes,
// request function codes, configuration register indexes and field widths.
// No dependencies; imported by the top level and its checker.
package napt_pkg;

   // Default log2 of the mapping store depth.
   localparam int MAX_POOL_BITS_DEF = 8;

   // Field widths.
   localparam int ADDR_W   = 32;
   localparam int FUNC_W   = 2;
   localparam int STATUS_W = 3;
   localparam int HOST_W   = 4;
   // Host bits widened so that the saturation limit (up to 16) fits.
   localparam int HOST_EXT_W = 5;
   // Configuration bus widths.
   localparam int PADDR_W = 4;
   localparam int PDATA_W = 32;

   // Request functions.
   localparam logic [FUNC_W-1:0] FN_INBOUND  = 2'd0;
   localparam logic [FUNC_W-1:0] FN_OUTBOUND = 2'd1;
   localparam logic [FUNC_W-1:0] FN_RELEASE  = 2'd2;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NOMAP    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_RELEASED = 3'd3;
   localparam logic [STATUS_W-1:0] ST_BADCOUNT = 3'd4;

   // Configuration register indexes (word address bits [3:2]).
   localparam logic [1:0] REG_POOL_ENABLE    = 2'd0;
   localparam logic [1:0] REG_POOL_BASE      = 2'd1;
   localparam logic [1:0] REG_POOL_HOST_BITS = 2'd2;

endpackage

// ----- hdl/nat_address_pool_table_top.sv -----
// Dynamic NAT address pool table: sequencer, mapping store and register port.
// Depends on napt_pkg.
//
// The block translates addresses against a public pool of up to
// 2^MAX_POOL_BITS entries held in a single-port-read, single-port-write
// memory. After reset a clearing pass writes zero to every entry, one per
// cycle, while req_ready stays low; register writes are taken during that
// pass. One request is worked at a time. An inbound request makes one
// memory read in S_INB_RD, checks it in S_INB_CHK and is answered from
// S_OUT; an outbound or release request scans the active pool with one
// memory read per cycle through one shared 32-bit compare, covering
// 2^bits entries, where bits is pool_host_bits saturated at MAX_POOL_BITS.
// A request that the pool cannot serve (disabled pool, address outside
// the pool, unused function) goes straight from S_IDLE to S_OUT. The
// response register frees the engine as soon as the response is loaded,
// and req_ready returns in that same cycle; while a stalled response
// still holds the register, the engine waits in its last step.
module nat_address_pool_table_top
   import napt_pkg::*;
#(
   parameter int MAX_POOL_BITS = MAX_POOL_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   // Request channel
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [FUNC_W-1:0]   req_func,
   input  logic [ADDR_W-1:0]   req_addr,
   // Response channel
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [ADDR_W-1:0]   rsp_new_addr,
   // Register port
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [PADDR_W-1:0]  paddr,
   input  logic [PDATA_W-1:0]  pwdata,
   output logic [PDATA_W-1:0]  prdata,
   output logic                pready
);

   localparam int AW    = MAX_POOL_BITS;
   localparam int DEPTH = 1 << AW;

   // Sequencer states.
   localparam logic [2:0] S_CLEAR   = 3'd0;
   localparam logic [2:0] S_IDLE    = 3'd1;
   localparam logic [2:0] S_SCAN    = 3'd2;
   localparam logic [2:0] S_INB_RD  = 3'd3;
   localparam logic [2:0] S_INB_CHK = 3'd4;
   localparam logic [2:0] S_FINISH  = 3'd5;
   localparam logic [2:0] S_OUT     = 3'd6;

   // Configuration registers.
   logic              enable_ff;
   logic [ADDR_W-1:0] base_ff;
   logic [HOST_W-1:0] host_bits_ff;

   // Sequencer registers.
   logic [2:0]          state_ff, state_in;
   logic [AW:0]         idx_ff, idx_in;
   logic                rd_vld_ff, rd_vld_in;
   logic [AW-1:0]       rd_idx_ff, rd_idx_in;
   logic [FUNC_W-1:0]   func_ff, func_in;
   logic [ADDR_W-1:0]   key_ff, key_in;
   logic [AW-1:0]       off_ff, off_in;
   logic                hit_ff, hit_in;
   logic [AW-1:0]       hit_idx_ff, hit_idx_in;
   logic                free_ff, free_in;
   logic [AW-1:0]       free_idx_ff, free_idx_in;
   logic [1:0]          cnt_ff, cnt_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [ADDR_W-1:0]   res_addr_ff, res_addr_in;

   // Response register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0]   rsp_new_addr_ff, rsp_new_addr_in;

   // Mapping store.
   logic [ADDR_W-1:0] mem [DEPTH];
   logic [ADDR_W-1:0] mem_rdata_ff;
   logic              mem_re;
   logic [AW-1:0]     mem_raddr;
   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   logic [ADDR_W-1:0] mem_wdata;

   // Derived values.
   logic [HOST_EXT_W-1:0] host_ext;
   logic [HOST_EXT_W-1:0] eff_bits;
   logic [AW:0]           pool_size;
   logic [ADDR_W:0]       off_full;
   logic                  in_range;
   logic                  rd_match;
   logic                  rd_empty;
   logic [AW-1:0]         sel_idx;
   logic [ADDR_W-1:0]     pub_addr;
   logic                  csr_wr;

   // Pool size with host bits saturated at the store depth.
   always_comb begin
      host_ext  = {1'b0, host_bits_ff};
      eff_bits  = (host_ext > HOST_EXT_W'(MAX_POOL_BITS)) ?
                  HOST_EXT_W'(MAX_POOL_BITS) : host_ext;
      pool_size = (AW + 1)'(1) << eff_bits;
   end

   // Inbound pool range check on the request address.
   assign off_full = {1'b0, req_addr} - {1'b0, base_ff};
   assign in_range = !off_full[ADDR_W] && (off_full[ADDR_W-1:0] < ADDR_W'(pool_size));

   // The shared compare unit and the public address adder.
   assign rd_match = (mem_rdata_ff == key_ff);
   assign rd_empty = (mem_rdata_ff == '0);
   assign sel_idx  = hit_ff ? hit_idx_ff : free_idx_ff;
   assign pub_addr = base_ff + ADDR_W'(sel_idx);

   // Register port: always ready, write on the access phase.
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= 1'b0;
         base_ff      <= '0;
         host_bits_ff <= '0;
      end else if (csr_wr) begin
         case (paddr[3:2])
            REG_POOL_ENABLE:    enable_ff    <= pwdata[0];
            REG_POOL_BASE:      base_ff      <= pwdata;
            REG_POOL_HOST_BITS: host_bits_ff <= pwdata[HOST_W-1:0];
            default: ;
         endcase
      end
   end

   // Register readback.
   always_comb begin
      case (paddr[3:2])
         REG_POOL_ENABLE:    prdata = {{(PDATA_W-1){1'b0}}, enable_ff};
         REG_POOL_BASE:      prdata = base_ff;
         REG_POOL_HOST_BITS: prdata = {{(PDATA_W-HOST_W){1'b0}}, host_bits_ff};
         default:            prdata = '0;
      endcase
   end

   // Sequencer next-state and memory control.
   always_comb begin
      state_in        = state_ff;
      idx_in          = idx_ff;
      rd_vld_in       = rd_vld_ff;
      rd_idx_in       = rd_idx_ff;
      func_in         = func_ff;
      key_in          = key_ff;
      off_in          = off_ff;
      hit_in          = hit_ff;
      hit_idx_in      = hit_idx_ff;
      free_in         = free_ff;
      free_idx_in     = free_idx_ff;
      cnt_in          = cnt_ff;
      res_status_in   = res_status_ff;
      res_addr_in     = res_addr_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_status_in   = rsp_status_ff;
      rsp_new_addr_in = rsp_new_addr_ff;
      mem_re          = 1'b0;
      mem_raddr       = idx_ff[AW-1:0];
      mem_we          = 1'b0;
      mem_waddr       = idx_ff[AW-1:0];
      mem_wdata       = '0;

      case (state_ff)
         // Zero every entry once after reset.
         S_CLEAR: begin
            mem_we = 1'b1;
            idx_in = idx_ff + 1'b1;
            if (idx_ff[AW-1:0] == AW'(DEPTH - 1)) begin
               idx_in   = '0;
               state_in = S_IDLE;
            end
         end

         // Take a request and decide which path it follows.
         S_IDLE: begin
            if (req_valid) begin
               func_in     = req_func;
               key_in      = req_addr;
               off_in      = off_full[AW-1:0];
               idx_in      = '0;
               rd_vld_in   = 1'b0;
               hit_in      = 1'b0;
               free_in     = 1'b0;
               cnt_in      = '0;
               res_addr_in = '0;
               case (req_func)
                  FN_INBOUND: begin
                     if (enable_ff && in_range) begin
                        state_in = S_INB_RD;
                     end else begin
                        res_status_in = ST_NOMAP;
                        state_in      = S_OUT;
                     end
                  end
                  FN_OUTBOUND: begin
                     if (enable_ff) begin
                        state_in = S_SCAN;
                     end else begin
                        res_status_in = ST_FULL;
                        state_in      = S_OUT;
                     end
                  end
                  FN_RELEASE: begin
                     if (enable_ff) begin
                        state_in = S_SCAN;
                     end else begin
                        res_status_in = ST_BADCOUNT;
                        state_in      = S_OUT;
                     end
                  end
                  default: begin
                     res_status_in = ST_NOMAP;
                     state_in      = S_OUT;
                  end
               endcase
            end
         end

         // Inbound lookup: one read at the pool offset.
         S_INB_RD: begin
            mem_re    = 1'b1;
            mem_raddr = off_ff;
            state_in  = S_INB_CHK;
         end

         S_INB_CHK: begin
            if (!rd_empty) begin
               res_status_in = ST_OK;
               res_addr_in   = mem_rdata_ff;
            end else begin
               res_status_in = ST_NOMAP;
               res_addr_in   = '0;
            end
            state_in = S_OUT;
         end

         // Scan the pool: issue one read per cycle, check the previous one.
         S_SCAN: begin
            if (idx_ff < pool_size) begin
               mem_re    = 1'b1;
               mem_raddr = idx_ff[AW-1:0];
               rd_vld_in = 1'b1;
               rd_idx_in = idx_ff[AW-1:0];
               idx_in    = idx_ff + 1'b1;
            end else begin
               rd_vld_in = 1'b0;
               if (!rd_vld_ff) begin
                  state_in = S_FINISH;
               end
            end
            if (rd_vld_ff) begin
               if (func_ff == FN_RELEASE) begin
                  // Clear each matching entry and count them, saturating at two.
                  if (rd_match) begin
                     mem_we    = 1'b1;
                     mem_waddr = rd_idx_ff;
                     cnt_in    = (cnt_ff == 2'd2) ? cnt_ff : cnt_ff + 1'b1;
                  end
               end else begin
                  // Remember the lowest matching and the lowest free entry.
                  if (rd_match && !hit_ff) begin
                     hit_in     = 1'b1;
                     hit_idx_in = rd_idx_ff;
                  end
                  if (rd_empty && !free_ff) begin
                     free_in     = 1'b1;
                     free_idx_in = rd_idx_ff;
                  end
               end
            end
         end

         // Resolve the scan: reuse, claim, or report.
         S_FINISH: begin
            res_addr_in = '0;
            if (func_ff == FN_OUTBOUND) begin
               if (hit_ff) begin
                  res_status_in = ST_OK;
                  res_addr_in   = pub_addr;
               end else if (free_ff) begin
                  mem_we        = 1'b1;
                  mem_waddr     = free_idx_ff;
                  mem_wdata     = key_ff;
                  res_status_in = ST_OK;
                  res_addr_in   = pub_addr;
               end else begin
                  res_status_in = ST_FULL;
               end
            end else begin
               res_status_in = (cnt_ff == 2'd1) ? ST_RELEASED : ST_BADCOUNT;
            end
            state_in = S_OUT;
         end

         // Hand the result to the response register once it is free.
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in    = 1'b1;
               rsp_status_in   = res_status_ff;
               rsp_new_addr_in = res_addr_ff;
               state_in        = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         idx_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         hit_ff       <= 1'b0;
         free_ff      <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rd_vld_ff    <= rd_vld_in;
         hit_ff       <= hit_in;
         free_ff      <= free_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      rd_idx_ff       <= rd_idx_in;
      func_ff         <= func_in;
      key_ff          <= key_in;
      off_ff          <= off_in;
      hit_idx_ff      <= hit_idx_in;
      free_idx_ff     <= free_idx_in;
      res_status_ff   <= res_status_in;
      res_addr_ff     <= res_addr_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_new_addr_ff <= rsp_new_addr_in;
   end

   // Mapping store: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rdata_ff <= mem[mem_raddr];
      end
   end

   assign req_ready    = (state_ff == S_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_new_addr = rsp_new_addr_ff;

endmodule

// ----- hdl/napt_checker.sv -----
// Port-level checks for the NAT address pool table, bound to its top level.
// Depends on napt_pkg and nat_address_pool_table_top.
module napt_port_checker
   import napt_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [ADDR_W-1:0]   rsp_new_addr
);

   // A stalled response keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_new_addr))
      else $error("response changed while stalled");

   // Only a translated response carries an address.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |-> (rsp_new_addr == '0))
      else $error("nonzero address on a dropped or release response");

   // Status stays within the defined codes.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ST_OK) || (rsp_status == ST_NOMAP) ||
                    (rsp_status == ST_FULL) || (rsp_status == ST_RELEASED) ||
                    (rsp_status == ST_BADCOUNT))
      else $error("undefined response status");

   // One request at a time: the engine is busy right after it takes a request.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a previous one is in work");

   // No response appears straight out of reset.
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind nat_address_pool_table_top napt_port_checker u_napt_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_status   (rsp_status),
   .rsp_new_addr (rsp_new_addr)
);
